@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define RCM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// property that must never hold
`define RCM_ASSERT_NEVER(name, prop, msg) `RCM_ASSERT(name, !(prop), msg)

`endif

@@ hw/rtl/rcm_pkg.sv @@
// shared types and constants of the rgba channel mixer
package rcm_pkg;

  localparam int NumLanes = 4;
  localparam int NumTerms = 5;
  localparam int IdxWidth = 3;

  // configuration register indexes
  typedef enum logic [IdxWidth-1:0] {
    REG_RED_COEF    = 3'd0,
    REG_GREEN_COEF  = 3'd1,
    REG_BLUE_COEF   = 3'd2,
    REG_ALPHA_COEF  = 3'd3,
    REG_RED_MODE    = 3'd4,
    REG_GREEN_MODE  = 3'd5,
    REG_BLUE_MODE   = 3'd6,
    REG_ALPHA_MODE  = 3'd7
  } reg_idx_e;

  // per-lane sign and zero-weight status traveling with the quotient
  typedef struct packed {
    logic neg;
    logic zero;
  } lane_side_t;

endpackage

@@ hw/rtl/rcm_lane.sv @@
// one mixing lane: weight factors, products, accumulation and divisor
module rcm_lane import rcm_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 12,
  localparam int AccWidth    = 2 * COEF_WIDTH + SAMPLE_WIDTH + 3,
  localparam int DenWidth    = 2 * COEF_WIDTH - 2
) (
  input  logic                                   clk_i,
  input  logic [NumTerms*COEF_WIDTH-1:0]         coefs_i,
  input  logic                                   mode_i,
  input  logic [NumLanes-1:0][SAMPLE_WIDTH-1:0]  samples_i,
  output logic signed [AccWidth-1:0]             acc_o,
  output logic [DenWidth-1:0]                    den_o,
  output lane_side_t                             side_o
);

  localparam int FacWidth  = 2 * COEF_WIDTH;
  localparam int ProdWidth = FacWidth + SAMPLE_WIDTH;
  localparam int WsWidth   = COEF_WIDTH + 3;
  localparam int Frac      = COEF_WIDTH - 4;

  logic signed [COEF_WIDTH-1:0]   w    [NumTerms];
  logic signed [FacWidth-1:0]     wx   [NumTerms];
  logic signed [FacWidth-1:0]     f_d  [NumTerms];
  logic signed [FacWidth-1:0]     f_q  [NumTerms];
  logic signed [SAMPLE_WIDTH-1:0] v_d  [NumTerms];
  logic signed [SAMPLE_WIDTH-1:0] v_q  [NumTerms];
  logic signed [ProdWidth-1:0]    fe   [NumTerms];
  logic signed [ProdWidth-1:0]    ve   [NumTerms];
  logic signed [ProdWidth-1:0]    p_d  [NumTerms];
  logic signed [ProdWidth-1:0]    p_q  [NumTerms];
  logic signed [AccWidth-1:0]     acc_d;
  logic signed [WsWidth-1:0]      wsum;
  logic signed [WsWidth-1:0]      wabs;
  logic [DenWidth-1:0]            den_d;
  lane_side_t                     side_d;

  // weight factor: plain weight for sum mode, squared weight for average mode
  always_comb begin
    for (int k = 0; k < NumTerms; k++) begin
      w[k]   = coefs_i[k*COEF_WIDTH +: COEF_WIDTH];
      wx[k]  = FacWidth'(w[k]);
      f_d[k] = mode_i ? wx[k] * wx[k] : wx[k];
    end
    for (int k = 0; k < NumLanes; k++) begin
      v_d[k] = samples_i[k];
    end
    v_d[NumTerms-1] = {{3{1'b0}}, 1'b1, {(SAMPLE_WIDTH-4){1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    f_q <= f_d;
    v_q <= v_d;
  end

  // one product per term
  always_comb begin
    for (int k = 0; k < NumTerms; k++) begin
      fe[k]  = ProdWidth'(f_q[k]);
      ve[k]  = ProdWidth'(v_q[k]);
      p_d[k] = fe[k] * ve[k];
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  // accumulate products, weight sum and divisor
  always_comb begin
    acc_d = '0;
    wsum  = '0;
    for (int k = 0; k < NumTerms; k++) begin
      acc_d = acc_d + AccWidth'(p_q[k]);
      wsum  = wsum + WsWidth'(w[k]);
    end
    wabs        = wsum[WsWidth-1] ? -wsum : wsum;
    den_d       = mode_i ? (DenWidth'(wabs) << Frac) : (DenWidth'(1) << Frac);
    side_d.neg  = acc_d[AccWidth-1] ^ (mode_i & wsum[WsWidth-1]);
    side_d.zero = mode_i & (wsum == '0);
  end

  always_ff @(posedge clk_i) begin
    acc_o  <= acc_d;
    den_o  <= den_d;
    side_o <= side_d;
  end

endmodule

@@ hw/rtl/rcm_divider.sv @@
// pipelined restoring divider, one quotient bit per stage, rounding to nearest
module rcm_divider import rcm_pkg::*; #(
  parameter int ACC_WIDTH = 43,
  parameter int DEN_WIDTH = 22,
  localparam int NumWidth = ACC_WIDTH + 1
) (
  input  logic                        clk_i,
  input  logic signed [ACC_WIDTH-1:0] acc_i,
  input  logic [DEN_WIDTH-1:0]        den_i,
  input  lane_side_t                  side_i,
  output logic [NumWidth-1:0]         quot_o,
  output lane_side_t                  side_o
);

  logic [NumWidth-1:0]  accx;
  logic [NumWidth-1:0]  half;
  logic [NumWidth-1:0]  n_d;

  logic [NumWidth-1:0]  nq [NumWidth+1];
  logic [DEN_WIDTH-1:0] rq [NumWidth];
  logic [DEN_WIDTH-1:0] dq [NumWidth];
  lane_side_t           sq [NumWidth+1];

  // magnitude plus half divisor, one adder for both signs
  always_comb begin
    accx = NumWidth'(acc_i);
    half = NumWidth'(den_i >> 1);
    if (acc_i[ACC_WIDTH-1]) begin
      n_d = ~accx + (half + NumWidth'(1));
    end else begin
      n_d = accx + half;
    end
  end

  always_ff @(posedge clk_i) begin
    nq[0] <= n_d;
    dq[0] <= den_i;
    sq[0] <= side_i;
  end

  assign rq[0] = '0;

  // one quotient bit per stage, shifted in where the dividend leaves
  for (genvar i = 0; i < NumWidth; i++) begin : g_stage
    logic [DEN_WIDTH:0]   t;
    logic                 ge;

    always_comb begin
      t  = {rq[i], nq[i][NumWidth-1]};
      ge = (t >= {1'b0, dq[i]});
    end

    always_ff @(posedge clk_i) begin
      nq[i+1] <= {nq[i][NumWidth-2:0], ge};
      sq[i+1] <= sq[i];
    end

    // partial remainder and divisor move on except after the last bit
    if (i < NumWidth - 1) begin : g_carry
      logic [DEN_WIDTH-1:0] rem_d;

      assign rem_d = ge ? DEN_WIDTH'(t - {1'b0, dq[i]}) : DEN_WIDTH'(t);

      always_ff @(posedge clk_i) begin
        rq[i+1] <= rem_d;
        dq[i+1] <= dq[i];
      end
    end
  end

  assign quot_o = nq[NumWidth];
  assign side_o = sq[NumWidth];

endmodule

@@ hw/rtl/rcm_merge.sv @@
// merge stage: sign, saturation and zero-weight flags of all lanes
module rcm_merge import rcm_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int NUM_WIDTH    = 44
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic [NumLanes-1:0][NUM_WIDTH-1:0]    quot_i,
  input  lane_side_t [NumLanes-1:0]             side_i,
  output logic                                  valid_o,
  output logic [NumLanes-1:0][SAMPLE_WIDTH-1:0] result_o,
  output logic [NumLanes-1:0]                   flags_o
);

  localparam logic [NUM_WIDTH-1:0] MaxPos =
    NUM_WIDTH'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
  localparam logic [NUM_WIDTH-1:0] MinMag = NUM_WIDTH'(64'd1 << (SAMPLE_WIDTH - 1));

  logic [NumLanes-1:0][SAMPLE_WIDTH-1:0] res_d;
  logic [NumLanes-1:0]                   flags_d;
  logic                                  valid_q;

  // zero flagged lanes, apply sign and clamp to the sample range
  always_comb begin
    for (int k = 0; k < NumLanes; k++) begin
      flags_d[k] = side_i[k].zero;
      if (side_i[k].zero) begin
        res_d[k] = '0;
      end else if (!side_i[k].neg) begin
        res_d[k] = (quot_i[k] > MaxPos) ? MaxPos[SAMPLE_WIDTH-1:0]
                                        : quot_i[k][SAMPLE_WIDTH-1:0];
      end else begin
        res_d[k] = (quot_i[k] > MinMag) ? MinMag[SAMPLE_WIDTH-1:0]
                                        : ~quot_i[k][SAMPLE_WIDTH-1:0] + SAMPLE_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // output register loads only on a finished request
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      result_o <= res_d;
      flags_o  <= flags_d;
    end
  end

  assign valid_o = valid_q;

endmodule

@@ hw/rtl/rgba_channel_mixer_unit.sv @@
// top level of the rgba channel mixer: configuration, lanes, dividers, merge
//
// Usage: drive red/green/blue/alpha_in_i (signed, 1.0 = 2^(SAMPLE_WIDTH-4))
// and pulse start; busy is always low, so a new request may enter on every
// clock. Each request yields one result on red/green/blue/alpha_out_o and
// zero_weight_flags_o, marked by valid_o for exactly one cycle.
// The path runs through the lane registers, then the divider, which resolves one
// quotient bit per pipeline stage in each of the four lanes, and then the merge
// output register.
// Throughput: one pixel per clock.
// Configuration: cfg_we_i with cfg_index_i and cfg_wdata_i writes one
// register; write only when no request is in flight.
// Reset: identity matrix, all channels in sum mode, pipeline emptied.
// The receiver cannot stall: valid_o is a strobe; results hold until the next one.
module rgba_channel_mixer_unit import rcm_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [SAMPLE_WIDTH-1:0] red_in_i,
  input  logic signed [SAMPLE_WIDTH-1:0] green_in_i,
  input  logic signed [SAMPLE_WIDTH-1:0] blue_in_i,
  input  logic signed [SAMPLE_WIDTH-1:0] alpha_in_i,
  input  logic                           cfg_we_i,
  input  logic [IdxWidth-1:0]            cfg_index_i,
  input  logic [5*COEF_WIDTH-1:0]        cfg_wdata_i,
  output logic                           valid_o,
  output logic signed [SAMPLE_WIDTH-1:0] red_out_o,
  output logic signed [SAMPLE_WIDTH-1:0] green_out_o,
  output logic signed [SAMPLE_WIDTH-1:0] blue_out_o,
  output logic signed [SAMPLE_WIDTH-1:0] alpha_out_o,
  output logic [NumLanes-1:0]            zero_weight_flags_o
);

  localparam int CoefBits  = NumTerms * COEF_WIDTH;
  localparam int AccWidth  = 2 * COEF_WIDTH + SAMPLE_WIDTH + 3;
  localparam int DenWidth  = 2 * COEF_WIDTH - 2;
  localparam int NumWidth  = AccWidth + 1;
  localparam int PipeDepth = NumWidth + 4;
  localparam logic [CoefBits-1:0] One = CoefBits'(1) << (COEF_WIDTH - 4);

  logic [NumLanes-1:0][CoefBits-1:0]     coef_q;
  logic [NumLanes-1:0]                   mode_q;
  logic [PipeDepth-1:0]                  vpipe_q;
  logic [NumLanes-1:0][SAMPLE_WIDTH-1:0] samples;
  logic signed [AccWidth-1:0]            acc      [NumLanes];
  logic [DenWidth-1:0]                   den      [NumLanes];
  lane_side_t                            lside    [NumLanes];
  logic [NumLanes-1:0][NumWidth-1:0]     quot;
  lane_side_t [NumLanes-1:0]             qside;
  logic [NumLanes-1:0][SAMPLE_WIDTH-1:0] result;

  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumLanes; k++) begin
        coef_q[k] <= One << (k * COEF_WIDTH);
      end
      mode_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_RED_COEF:   coef_q[0] <= cfg_wdata_i;
        REG_GREEN_COEF: coef_q[1] <= cfg_wdata_i;
        REG_BLUE_COEF:  coef_q[2] <= cfg_wdata_i;
        REG_ALPHA_COEF: coef_q[3] <= cfg_wdata_i;
        REG_RED_MODE:   mode_q[0] <= cfg_wdata_i[0];
        REG_GREEN_MODE: mode_q[1] <= cfg_wdata_i[0];
        REG_BLUE_MODE:  mode_q[2] <= cfg_wdata_i[0];
        REG_ALPHA_MODE: mode_q[3] <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // request tracking alongside the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vpipe_q <= '0;
    end else begin
      vpipe_q <= {vpipe_q[PipeDepth-2:0], start};
    end
  end

  assign samples = {alpha_in_i, blue_in_i, green_in_i, red_in_i};

  // one lane and one divider per output channel
  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    rcm_lane #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
    ) u_lane (
      .clk_i    (clk_i),
      .coefs_i  (coef_q[l]),
      .mode_i   (mode_q[l]),
      .samples_i(samples),
      .acc_o    (acc[l]),
      .den_o    (den[l]),
      .side_o   (lside[l])
    );

    rcm_divider #(
      .ACC_WIDTH(AccWidth),
      .DEN_WIDTH(DenWidth)
    ) u_div (
      .clk_i (clk_i),
      .acc_i (acc[l]),
      .den_i (den[l]),
      .side_i(lside[l]),
      .quot_o(quot[l]),
      .side_o(qside[l])
    );
  end

  rcm_merge #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .NUM_WIDTH   (NumWidth)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vpipe_q[PipeDepth-1]),
    .quot_i  (quot),
    .side_i  (qside),
    .valid_o (valid_o),
    .result_o(result),
    .flags_o (zero_weight_flags_o)
  );

  assign red_out_o   = result[0];
  assign green_out_o = result[1];
  assign blue_out_o  = result[2];
  assign alpha_out_o = result[3];

endmodule

@@ hw/rtl/rcm_checker.sv @@
// port-level checks of the rgba channel mixer, bound to the top level
`include "assert_macros.svh"

module rcm_checker import rcm_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 12
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic                           valid_o,
  input logic signed [SAMPLE_WIDTH-1:0] red_out_o,
  input logic signed [SAMPLE_WIDTH-1:0] alpha_out_o,
  input logic [NumLanes-1:0]            zero_weight_flags_o
);

  localparam int Latency = 2 * COEF_WIDTH + SAMPLE_WIDTH + 9;

  // fully pipelined: never refuses a request
  `RCM_ASSERT_NEVER(a_never_busy, busy, "busy raised")

  // every result strobe comes from a request accepted a fixed latency earlier
  `RCM_ASSERT(a_result_latency, valid_o |-> $past(start, Latency), "result without request")

  // a flagged red or alpha channel reads zero
  `RCM_ASSERT(a_red_zero, (valid_o && zero_weight_flags_o[0]) |-> red_out_o == '0, "red flag")

  `RCM_ASSERT(a_alpha_zero, (valid_o && zero_weight_flags_o[3]) |-> alpha_out_o == '0,
    "alpha flag")

endmodule

bind rgba_channel_mixer_unit rcm_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH),
  .COEF_WIDTH  (COEF_WIDTH)
) u_rcm_checker (.*);
